// ----- src/sac_pkg.sv -----
// ---------------------------------------------------------------------------
// sac_pkg
// Shared types and constants for the sphere / box contact pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package sac_pkg;

  localparam int SqrtSteps = 31;   // result bits of the distance root
  localparam int DivSteps  = 17;   // quotient bits of a normal component

  localparam logic [63:0] NearZeroSq = 64'd49;
  localparam logic [17:0] UnitPos    = 18'h10000;
  localparam logic [17:0] UnitNeg    = 18'h30000;
  localparam logic [16:0] UnitQ      = 17'h10000;
  localparam logic [30:0] PenMax     = 31'h7FFFFFFF;

  typedef logic [2:0][31:0] vec32_t;
  typedef logic [2:0][30:0] vec31_t;
  typedef logic [2:0][17:0] vec18_t;

  // Per-item context that rides along the root and divide stages
  typedef struct packed {
    logic        hit;
    logic        near;
    logic [2:0]  neg;
    vec31_t      mag;
    logic [30:0] rad;
    vec32_t      pt;
    vec18_t      near_nrm;
    logic [30:0] near_pen;
  } ctx_t;

endpackage
`default_nettype wire

// ----- src/sac_front.sv -----
// ---------------------------------------------------------------------------
// sac_front
// Clamp, offsets, face choice, squares and hit test in four register stages.
// ---------------------------------------------------------------------------
`default_nettype none
module sac_front import sac_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        v_i,
  input  wire vec32_t      sph_i,
  input  wire logic [30:0] rad_i,
  input  wire vec32_t      box_i,
  input  wire vec31_t      half_i,
  output logic             v_o,
  output ctx_t             ctx_o,
  output logic [61:0]      dsq_o
);

  // stage 1 signals
  logic signed [34:0] s_w  [3];
  logic signed [34:0] b_w  [3];
  logic signed [34:0] lo_w [3];
  logic signed [34:0] hi_w [3];
  logic signed [34:0] p_w  [3];
  logic signed [34:0] fl_w [3];
  logic signed [34:0] fh_w [3];

  logic               v1_r;
  logic signed [34:0] d1_r    [3];
  logic signed [34:0] face1_r [3];
  vec32_t             pt1_r;
  logic [2:0]         above1_r;
  logic [30:0]        rad1_r;

  // stage 2 signals
  logic [34:0]        mag_w [3];
  logic [1:0]         ax_w;
  logic signed [35:0] psum_w;

  logic               v2_r;
  vec31_t             mag2_r;
  logic [2:0]         neg2_r;
  logic               miss2_r, miss2_nxt;
  vec18_t             nrm2_r, nrm2_nxt;
  logic [30:0]        pen2_r, pen2_nxt;
  vec32_t             pt2_r;
  logic [30:0]        rad2_r;

  // stage 3 signals
  logic               v3_r;
  logic [61:0]        sq3_r [3];
  logic [61:0]        rsq3_r;
  logic               miss3_r;
  logic [2:0]         neg3_r;
  vec31_t             mag3_r;
  vec18_t             nrm3_r;
  logic [30:0]        pen3_r;
  vec32_t             pt3_r;
  logic [30:0]        rad3_r;

  logic [63:0]        dsq_w;

  // Box bounds, clamp and face distances per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_w[i]  = 35'(signed'(sph_i[i]));
      b_w[i]  = 35'(signed'(box_i[i]));
      lo_w[i] = b_w[i] - signed'({4'b0, half_i[i]});
      hi_w[i] = b_w[i] + signed'({4'b0, half_i[i]});
      if (s_w[i] > hi_w[i]) begin
        p_w[i] = hi_w[i];
      end else if (s_w[i] < lo_w[i]) begin
        p_w[i] = lo_w[i];
      end else begin
        p_w[i] = s_w[i];
      end
      fl_w[i] = s_w[i] - lo_w[i];
      fh_w[i] = hi_w[i] - s_w[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i]     <= s_w[i] - p_w[i];
        face1_r[i]  <= (fl_w[i] < fh_w[i]) ? fl_w[i] : fh_w[i];
        pt1_r[i]    <= p_w[i][31:0];
        above1_r[i] <= s_w[i] > b_w[i];
      end
      rad1_r <= rad_i;
    end
  end

  // Magnitudes, per-axis miss and the shallow-face result
  always_comb begin
    miss2_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag_w[i] = d1_r[i][34] ? 35'(-d1_r[i]) : 35'(d1_r[i]);
      if (mag_w[i] >= {4'b0, rad1_r}) begin
        miss2_nxt = 1'b1;
      end
    end
    if (face1_r[0] < face1_r[1] && face1_r[0] < face1_r[2]) begin
      ax_w = 2'd0;
    end else if (face1_r[1] < face1_r[2]) begin
      ax_w = 2'd1;
    end else begin
      ax_w = 2'd2;
    end
    psum_w   = 36'(face1_r[ax_w]) + signed'({5'b0, rad1_r});
    nrm2_nxt = '0;
    nrm2_nxt[ax_w] = above1_r[ax_w] ? UnitPos : UnitNeg;
    if (psum_w < 0) begin
      pen2_nxt = '0;
    end else if (psum_w > signed'({5'b0, PenMax})) begin
      pen2_nxt = PenMax;
    end else begin
      pen2_nxt = psum_w[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag2_r[i] <= mag_w[i][30:0];
        neg2_r[i] <= d1_r[i][34];
      end
      miss2_r <= miss2_nxt;
      nrm2_r  <= nrm2_nxt;
      pen2_r  <= pen2_nxt;
      pt2_r   <= pt1_r;
      rad2_r  <= rad1_r;
    end
  end

  // Squares of the offsets and the radius
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq3_r[i] <= {31'b0, mag2_r[i]} * {31'b0, mag2_r[i]};
      end
      rsq3_r  <= {31'b0, rad2_r} * {31'b0, rad2_r};
      miss3_r <= miss2_r;
      neg3_r  <= neg2_r;
      mag3_r  <= mag2_r;
      nrm3_r  <= nrm2_r;
      pen3_r  <= pen2_r;
      pt3_r   <= pt2_r;
      rad3_r  <= rad2_r;
    end
  end

  // Sum and compare against radius squared
  assign dsq_w = {2'b0, sq3_r[0]} + {2'b0, sq3_r[1]} + {2'b0, sq3_r[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_o.hit      <= !miss3_r && (dsq_w < {2'b0, rsq3_r});
      ctx_o.near     <= dsq_w < NearZeroSq;
      ctx_o.neg      <= neg3_r;
      ctx_o.mag      <= mag3_r;
      ctx_o.rad      <= rad3_r;
      ctx_o.pt       <= pt3_r;
      ctx_o.near_nrm <= nrm3_r;
      ctx_o.near_pen <= pen3_r;
      dsq_o          <= dsq_w[61:0];
    end
  end

endmodule
`default_nettype wire

// ----- src/sac_sqrt_stage.sv -----
// ---------------------------------------------------------------------------
// sac_sqrt_stage
// One result bit of the integer square root, registered.
// ---------------------------------------------------------------------------
`default_nettype none
module sac_sqrt_stage import sac_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        v_i,
  input  wire ctx_t        ctx_i,
  input  wire logic [31:0] rem_i,
  input  wire logic [30:0] root_i,
  input  wire logic [61:0] rad_i,
  output logic             v_o,
  output ctx_t             ctx_o,
  output logic [31:0]      rem_o,
  output logic [30:0]      root_o,
  output logic [61:0]      rad_o
);

  logic [33:0] cur_w;
  logic [33:0] trial_w;
  logic [33:0] diff_w;
  logic        take_w;

  // Bring down two radicand bits and try the next root bit
  assign cur_w   = {rem_i, rad_i[61:60]};
  assign trial_w = {1'b0, root_i, 2'b01};
  assign diff_w  = cur_w - trial_w;
  assign take_w  = cur_w >= trial_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_o  <= ctx_i;
      rem_o  <= take_w ? diff_w[31:0] : cur_w[31:0];
      root_o <= {root_i[29:0], take_w};
      rad_o  <= {rad_i[59:0], 2'b00};
    end
  end

endmodule
`default_nettype wire

// ----- src/sac_div_stage.sv -----
// ---------------------------------------------------------------------------
// sac_div_stage
// One quotient bit of the three normal divisions, registered.
// ---------------------------------------------------------------------------
`default_nettype none
module sac_div_stage import sac_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        v_i,
  input  wire ctx_t        ctx_i,
  input  wire logic [30:0] dist_i,
  input  wire vec31_t      rem_i,
  input  wire logic [2:0][16:0] low_i,
  input  wire logic [2:0][16:0] q_i,
  output logic             v_o,
  output ctx_t             ctx_o,
  output logic [30:0]      dist_o,
  output vec31_t           rem_o,
  output logic [2:0][16:0] low_o,
  output logic [2:0][16:0] q_o
);

  logic [31:0] cur_w [3];
  logic        take_w [3];

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cur_w[i]  = {rem_i[i], low_i[i][16]};
      take_w[i] = cur_w[i] >= {1'b0, dist_i};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_o  <= ctx_i;
      dist_o <= dist_i;
      for (int i = 0; i < 3; i++) begin
        rem_o[i] <= take_w[i] ? 31'(cur_w[i] - {1'b0, dist_i}) : cur_w[i][30:0];
        low_o[i] <= {low_i[i][15:0], 1'b0};
        q_o[i]   <= {q_i[i][15:0], take_w[i]};
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/sphere_aabb_contact.sv -----
// ---------------------------------------------------------------------------
// sphere_aabb_contact
// Contact test of one sphere against one axis-aligned box, Q16.16.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one sphere / box pair per item on in_tdata.
//   Result channel out_*: one contact item per input item; out_tuser is the
//   hit flag, out_tdata holds normal, penetration and contact point. A miss
//   returns all zeros.
//   The pipe has 4 front stages (clamp, magnitude, squares, hit
//   compare), 31 square root stages at one root bit each, 17 divide stages
//   at one quotient bit each, and the output register.
//   Throughput is one item per cycle while no result is stalled; every stage
//   is a register with a valid bit and the whole pipe advances together.
//   When the receiver stalls with a result waiting, the pipe holds and
//   in_tready falls; bubbles still let the pipe advance.
//   Reset (rst_n low, synchronous) clears all valid bits; no item is
//   in flight afterwards and no result is shown.
// ---------------------------------------------------------------------------
`default_nettype none
module sphere_aabb_contact import sac_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // sphere_x[31:0] sphere_y[63:32] sphere_z[95:64] sphere_radius[126:96]
  // box_x[158:127] box_y[190:159] box_z[222:191] half_x[253:223]
  // half_y[284:254] half_z[315:285], zero fill [319:316]
  input  wire logic [319:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // normal_x[17:0] normal_y[35:18] normal_z[53:36] penetration[84:54]
  // point_x[116:85] point_y[148:117] point_z[180:149], zero fill [183:181]
  output logic [183:0]      out_tdata,
  // hit[0]
  output logic              out_tuser
);

  logic        en;
  vec32_t      sph_w, box_w;
  vec31_t      half_w;

  logic        fv_w;
  ctx_t        fctx_w;
  logic [61:0] fdsq_w;

  logic        sv_w    [SqrtSteps+1];
  ctx_t        sctx_w  [SqrtSteps+1];
  logic [31:0] srem_w  [SqrtSteps+1];
  logic [30:0] sroot_w [SqrtSteps+1];
  logic [61:0] srad_w  [SqrtSteps+1];

  logic             dv_w    [DivSteps+1];
  ctx_t             dctx_w  [DivSteps+1];
  logic [30:0]      ddist_w [DivSteps+1];
  vec31_t           drem_w  [DivSteps+1];
  logic [2:0][16:0] dlow_w  [DivSteps+1];
  logic [2:0][16:0] dq_w    [DivSteps+1];

  logic [47:0] num_w [3];
  logic [30:0] dist_w;
  logic [16:0] qc_w  [3];

  logic        out_tvalid_nxt;
  logic [183:0] out_tdata_nxt;
  logic        out_tuser_nxt;
  vec18_t      nrm_w;
  logic [30:0] pen_w;
  logic [30:0] pdiff_w;
  ctx_t        lctx_w;

  // Advance the whole pipe unless a result is waiting and stalled
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Unpack the input item
  assign sph_w[0]  = in_tdata[31:0];
  assign sph_w[1]  = in_tdata[63:32];
  assign sph_w[2]  = in_tdata[95:64];
  assign box_w[0]  = in_tdata[158:127];
  assign box_w[1]  = in_tdata[190:159];
  assign box_w[2]  = in_tdata[222:191];
  assign half_w[0] = in_tdata[253:223];
  assign half_w[1] = in_tdata[284:254];
  assign half_w[2] = in_tdata[315:285];

  sac_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (in_tvalid),
    .sph_i  (sph_w),
    .rad_i  (in_tdata[126:96]),
    .box_i  (box_w),
    .half_i (half_w),
    .v_o    (fv_w),
    .ctx_o  (fctx_w),
    .dsq_o  (fdsq_w)
  );

  // Square root chain
  assign sv_w[0]    = fv_w;
  assign sctx_w[0]  = fctx_w;
  assign srem_w[0]  = '0;
  assign sroot_w[0] = '0;
  assign srad_w[0]  = fdsq_w;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    sac_sqrt_stage u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (sv_w[k]),
      .ctx_i  (sctx_w[k]),
      .rem_i  (srem_w[k]),
      .root_i (sroot_w[k]),
      .rad_i  (srad_w[k]),
      .v_o    (sv_w[k+1]),
      .ctx_o  (sctx_w[k+1]),
      .rem_o  (srem_w[k+1]),
      .root_o (sroot_w[k+1]),
      .rad_o  (srad_w[k+1])
    );
  end

  // Rounded dividend: offset shifted left by 16 plus half the distance
  assign dist_w = sroot_w[SqrtSteps];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_w[i] = {1'b0, sctx_w[SqrtSteps].mag[i], 16'b0} + {18'b0, dist_w[30:1]};
    end
  end

  assign dv_w[0]    = sv_w[SqrtSteps];
  assign dctx_w[0]  = sctx_w[SqrtSteps];
  assign ddist_w[0] = dist_w;
  assign dq_w[0]    = '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      drem_w[0][i] = num_w[i][47:17];
      dlow_w[0][i] = num_w[i][16:0];
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    sac_div_stage u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (dv_w[k]),
      .ctx_i  (dctx_w[k]),
      .dist_i (ddist_w[k]),
      .rem_i  (drem_w[k]),
      .low_i  (dlow_w[k]),
      .q_i    (dq_w[k]),
      .v_o    (dv_w[k+1]),
      .ctx_o  (dctx_w[k+1]),
      .dist_o (ddist_w[k+1]),
      .rem_o  (drem_w[k+1]),
      .low_o  (dlow_w[k+1]),
      .q_o    (dq_w[k+1])
    );
  end

  // Select the result: miss, centre inside or near the box surface, or normalized offset
  assign lctx_w  = dctx_w[DivSteps];
  assign pdiff_w = lctx_w.rad - ddist_w[DivSteps];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc_w[i] = (dq_w[DivSteps][i] > UnitQ) ? UnitQ : dq_w[DivSteps][i];
    end
    if (!lctx_w.hit) begin
      nrm_w = '0;
      pen_w = '0;
    end else if (lctx_w.near) begin
      nrm_w = lctx_w.near_nrm;
      pen_w = lctx_w.near_pen;
    end else begin
      for (int i = 0; i < 3; i++) begin
        nrm_w[i] = lctx_w.neg[i] ? 18'(-{1'b0, qc_w[i]}) : {1'b0, qc_w[i]};
      end
      pen_w = (ddist_w[DivSteps] > lctx_w.rad) ? 31'd0 : pdiff_w;
    end
    out_tvalid_nxt = dv_w[DivSteps];
    out_tuser_nxt  = lctx_w.hit;
    out_tdata_nxt  = {3'b0,
                      lctx_w.hit ? lctx_w.pt[2] : 32'd0,
                      lctx_w.hit ? lctx_w.pt[1] : 32'd0,
                      lctx_w.hit ? lctx_w.pt[0] : 32'd0,
                      pen_w, nrm_w[2], nrm_w[1], nrm_w[0]};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= out_tdata_nxt;
      out_tuser <= out_tuser_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- test/sphere_aabb_contact_chk.sv -----
// ---------------------------------------------------------------------------
// sphere_aabb_contact_chk
// Watches both channels of the contact block, predicts each contact item
// from the accepted sphere / box pair and compares it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module sphere_aabb_contact_chk (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  // sphere_x, sphere_y, sphere_z, sphere_radius, box_x, box_y, box_z,
  // half_x, half_y, half_z, zero fill
  input  wire logic [319:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  // normal_x, normal_y, normal_z, penetration, point_x, point_y, point_z
  input  wire logic [183:0] out_tdata,
  // hit
  input  wire logic         out_tuser,
  output int                fail_cnt,
  output int                pending_cnt
);

  typedef struct packed {
    logic        hit;
    logic [17:0] nx, ny, nz;
    logic [30:0] pen;
    logic [31:0] px, py, pz;
  } contact_t;

  contact_t contact_q[$];

  // Bitwise integer square root, floor
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic contact_t predict_contact(input logic [319:0] d);
    longint s[3], c[3], lo[3], hi[3], off[3], face[3], nrm[3], p, r, pen;
    logic [63:0] dsq, mag, dlen, q;
    contact_t res;
    int ax;
    r = longint'(d[126:96]);
    s[0] = longint'($signed(d[31:0]));
    s[1] = longint'($signed(d[63:32]));
    s[2] = longint'($signed(d[95:64]));
    c[0] = longint'($signed(d[158:127]));
    c[1] = longint'($signed(d[190:159]));
    c[2] = longint'($signed(d[222:191]));
    lo[0] = c[0] - longint'(d[253:223]);
    hi[0] = c[0] + longint'(d[253:223]);
    lo[1] = c[1] - longint'(d[284:254]);
    hi[1] = c[1] + longint'(d[284:254]);
    lo[2] = c[2] - longint'(d[315:285]);
    hi[2] = c[2] + longint'(d[315:285]);
    res = '0;
    dsq = 0;
    for (int i = 0; i < 3; i++) begin
      p = s[i];
      if (p > hi[i]) p = hi[i];
      if (p < lo[i]) p = lo[i];
      off[i] = s[i] - p;
      face[i] = (s[i] - lo[i] < hi[i] - s[i]) ? s[i] - lo[i] : hi[i] - s[i];
      nrm[i] = 0;
      if (i == 0) res.px = p[31:0];
      if (i == 1) res.py = p[31:0];
      if (i == 2) res.pz = p[31:0];
    end
    for (int i = 0; i < 3; i++) begin
      mag = (off[i] < 0) ? -off[i] : off[i];
      if (mag >= r) return '0;
      dsq = dsq + mag * mag;
    end
    if (dsq >= r * r) return '0;
    if (dsq < 64'd49) begin
      if (face[0] < face[1] && face[0] < face[2]) ax = 0;
      else if (face[1] < face[2]) ax = 1;
      else ax = 2;
      nrm[ax] = (s[ax] - c[ax] > 0) ? 65536 : -65536;
      pen = face[ax] + r;
    end else begin
      dlen = root_floor(dsq);
      for (int i = 0; i < 3; i++) begin
        mag = (off[i] < 0) ? -off[i] : off[i];
        q = (mag * 65536 + dlen / 2) / dlen;
        if (q > 65536) q = 65536;
        nrm[i] = (off[i] < 0) ? -longint'(q) : longint'(q);
      end
      pen = r - longint'(dlen);
    end
    if (pen < 0) pen = 0;
    if (pen > 64'h7FFFFFFF) pen = 64'h7FFFFFFF;
    res.hit = 1'b1;
    res.nx = nrm[0][17:0];
    res.ny = nrm[1][17:0];
    res.nz = nrm[2][17:0];
    res.pen = pen[30:0];
    return res;
  endfunction

  assign pending_cnt = contact_q.size();

  // Predict on every accepted pair, compare on every accepted result
  always @(posedge clk) begin
    contact_t got, want;
    if (!rst_n) begin
      fail_cnt <= 0;
    end else begin
      if (in_tvalid && in_tready) contact_q.push_back(predict_contact(in_tdata));
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[17:0], out_tdata[35:18], out_tdata[53:36],
               out_tdata[84:54], out_tdata[116:85], out_tdata[148:117],
               out_tdata[180:149]};
        if (contact_q.size() == 0) begin
          $display("%0t: unexpected contact item %h", $time, got);
          fail_cnt <= fail_cnt + 1;
        end else begin
          want = contact_q.pop_front();
          if (got.hit !== want.hit || got.nx !== want.nx || got.ny !== want.ny ||
              got.nz !== want.nz || got.pen !== want.pen || got.px !== want.px ||
              got.py !== want.py || got.pz !== want.pz || out_tdata[183:181] !== 0) begin
            $display("%0t: contact mismatch expected hit=%b n=%h/%h/%h pen=%h p=%h/%h/%h",
                     $time, want.hit, want.nx, want.ny, want.nz, want.pen,
                     want.px, want.py, want.pz);
            $display("%0t:                   actual hit=%b n=%h/%h/%h pen=%h p=%h/%h/%h",
                     $time, got.hit, got.nx, got.ny, got.nz, got.pen,
                     got.px, got.py, got.pz);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- test/sphere_aabb_contact_tb.sv -----
// ---------------------------------------------------------------------------
// sphere_aabb_contact_tb
// Streams directed and random sphere / box pairs through the contact block
// with bursty input and a stalling receiver; the checker judges results.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module sphere_aabb_contact_tb;

  localparam int Latency = 53;
  localparam int CycleLimit = 200000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [319:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [183:0] out_tdata;
  logic         out_tuser;
  int           fail_cnt, pending_cnt;
  int           cycle_cnt = 0;
  int           hold_off = 0;
  int           n_sent = 0;

  always #5 clk = ~clk;

  sphere_aabb_contact dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  sphere_aabb_contact_chk chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .fail_cnt, .pending_cnt
  );

  // Timeout guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: long hold-off when requested, else random stalls in runs
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if ((cycle_cnt / 300) % 3 == 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic logic [319:0] pack_pair(
      input logic [31:0] sx, sy, sz, input logic [30:0] r,
      input logic [31:0] bx, by, bz, input logic [30:0] hx, hy, hz);
    return {4'b0, hz, hy, hx, bz, by, bx, r, sz, sy, sx};
  endfunction

  // Mostly nearby pairs so hits and both contact kinds are common
  function automatic logic [319:0] rand_pair();
    logic [31:0] b[3], s[3];
    logic [30:0] h[3], r;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      b[i] = (mode < 2) ? $urandom : $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
      h[i] = (mode < 2) ? 31'($urandom) : 31'($urandom_range(0, 32'h0040_0000));
      s[i] = (mode < 2) ? $urandom : b[i] + $signed($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
      if (mode == 2) s[i] = b[i] + $urandom_range(0, 40) - 20;
    end
    r = (mode < 2) ? 31'($urandom) : (mode == 3) ? 31'($urandom_range(0, 10))
                                                 : 31'($urandom_range(0, 32'h0060_0000));
    if (mode == 4) r = 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
    return pack_pair(s[0], s[1], s[2], r, b[0], b[1], b[2], h[0], h[1], h[2]);
  endfunction

  task automatic send_pair(input logic [319:0] d);
    in_tdata <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  // Drop valid for the requested gap; a zero gap keeps the stream back to back
  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  initial begin
    int burst;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, misses, inside faces and their ties, saturation
    send_pair('0);
    send_pair(pack_pair(0, 0, 0, 31'h10000, 0, 0, 0, 0, 0, 0));
    send_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 31'h10000, 31'h10000, 31'h10000));
    send_pair(pack_pair(32'h100, 0, 0, 31'h10000, 0, 0, 0, 31'h1000, 31'h2000, 31'h3000));
    send_pair(pack_pair(0, 32'h100, 0, 31'h10000, 0, 0, 0, 31'h1000, 31'h1000, 31'h1000));
    send_pair(pack_pair(0, 0, 32'hFFFF_FF00, 31'h10000, 0, 0, 0, 31'h2000, 31'h1000, 31'h1000));
    send_pair(pack_pair(0, 0, 0, 31'h10000, 0, 0, 0, 31'h3000, 31'h2000, 31'h1000));
    send_pair(pack_pair(32'h18000, 0, 0, 31'h10000, 0, 0, 0, 31'h8000, 31'h8000, 31'h8000));
    send_pair(pack_pair(32'hFFFF_0000, 32'hFFFF_0000, 0, 31'h10000, 0, 0, 0,
                        31'h8000, 31'h8000, 31'h8000));
    send_pair(pack_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_pair(pack_pair(0, 0, 0, 31'h7FFF_FFFF, 0, 0, 0,
                        31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_pair(pack_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
    send_pair(pack_pair(32'h10003, 0, 0, 31'h10000, 0, 0, 0, 31'h10000, 31'h10000, 31'h10000));
    send_pair({4'hF, 316'h0});
    send_pair({4'h0, {316{1'b1}}});
    idle_gap(1);

    // Long receiver hold-off while the sender keeps offering
    hold_off = 200;
    for (int i = 0; i < 100; i++) send_pair(rand_pair());
    idle_gap(1);

    // Let everything drain once
    while (pending_cnt != 0) @(negedge clk);

    // Random bursts with random gaps
    while (n_sent < 630) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++) send_pair(rand_pair());
      idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
    end
    in_tvalid <= 1'b0;

    while (pending_cnt != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
    $display("Sent %0d sphere/box pairs: misses, inside faces, ties, offsets and saturation.",
             n_sent);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
